// File: hdl/psfr_pkg.sv
// Package for the particle sensor frame receiver.
// Frame layout constants, result codes and the frame record passed front to back.
// No dependencies.
package psfr_pkg;

	localparam int WORD_COUNT = 12;
	localparam int IDX_W      = 4;
	localparam int POS_W      = 5;

	localparam logic [7:0]       HDR_FIRST   = 8'h42;
	localparam logic [7:0]       HDR_SECOND  = 8'h4d;
	localparam logic [POS_W-1:0] SUM_END     = 5'd30;
	localparam logic [POS_W-1:0] FRAME_LAST  = 5'd31;
	localparam logic [POS_W-1:0] WORD_FIRST  = 5'd5;
	localparam logic [POS_W-1:0] WORD_LAST   = 5'd27;
	localparam logic [IDX_W-1:0] WORD_OFFSET = 4'd2;
	localparam logic [IDX_W-1:0] IDX_LAST    = 4'(WORD_COUNT - 1);

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_START_ERR = 2'd1;
	localparam logic [1:0] STATUS_SUM_ERR   = 2'd2;

	// one judged frame: verdict plus a snapshot of its words
	typedef struct packed {
		logic [1:0]                  status;
		logic [WORD_COUNT-1:0][15:0] words;
	} frame_rec_t;

	// push side of the frame queue
	typedef struct packed {
		logic       push;
		frame_rec_t rec;
	} frame_push_t;

endpackage

// File: hdl/particle_sensor_frame_receiver.sv
// Top level of the particle sensor frame receiver.
// Instantiates psfr_front, psfr_queue and psfr_back; uses psfr_pkg.
//
// Channel   Dir  Handshake            Payload
// rx        in   rx_valid / rx_stall  rx_byte[7:0]
// res       out  res_valid/res_stall  frame_status[1:0], word_index[3:0],
//                                     word_value[15:0], last_of_frame
//
// One byte per cycle is taken while rx_stall is low. A good frame gives
// twelve results, an errored frame one; the back sequencer paces them at
// one per cycle while res_stall is low. Frame records wait in a two-entry
// queue; rx_stall rises only on a frame's last byte while the queue is full.
// Reset (arst_n low) puts the byte position at the start of a frame; framing
// is counted from reset with no search for the header.
module particle_sensor_frame_receiver import psfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  frame_status,
	output logic [3:0]  word_index,
	output logic [15:0] word_value,
	output logic        last_of_frame
);

	frame_push_t push;
	logic        q_full;
	logic        head_valid;
	frame_rec_t  head;
	logic        pop;

	// byte side: framing, header, sum and word capture
	psfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push)
	);

	// judged frames wait here so each side stalls on its own
	psfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// result side: one transaction per word, or one for an errored frame
	psfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.frame_status  (frame_status),
		.word_index    (word_index),
		.word_value    (word_value),
		.last_of_frame (last_of_frame)
	);

endmodule

// File: hdl/psfr_front.sv
// Front part: byte position, header check, running sum and word capture.
// Judges each frame at its last byte and pushes a record. Uses psfr_pkg.
module psfr_front import psfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        q_full,
	output frame_push_t push
);

	logic [POS_W-1:0]            pos_q;
	logic [15:0]                 sum_q;
	logic                        hdr_good_q;
	logic [7:0]                  hi_q;
	logic [WORD_COUNT-1:0][15:0] store_q;

	logic             accept;
	logic [15:0]      check;
	logic [IDX_W-1:0] widx;
	logic             wr_word;

	assign rx_stall = (pos_q == FRAME_LAST) && q_full;
	assign accept   = rx_valid && !rx_stall;
	assign check    = {hi_q, rx_byte};
	assign widx     = pos_q[POS_W-1:1] - WORD_OFFSET;
	assign wr_word  = pos_q[0] && (pos_q >= WORD_FIRST) && (pos_q <= WORD_LAST);

	always_comb begin
		push.push       = accept && (pos_q == FRAME_LAST);
		push.rec.words  = store_q;
		if (!hdr_good_q)
			push.rec.status = STATUS_START_ERR;
		else if (sum_q != check)
			push.rec.status = STATUS_SUM_ERR;
		else
			push.rec.status = STATUS_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			sum_q      <= '0;
			hdr_good_q <= 1'b1;
			hi_q       <= '0;
		end else if (accept) begin
			pos_q <= pos_q + 1'b1;
			if (pos_q == '0) begin
				hdr_good_q <= (rx_byte == HDR_FIRST);
				sum_q      <= {8'd0, rx_byte};
			end else begin
				if (pos_q == 5'd1)
					hdr_good_q <= hdr_good_q && (rx_byte == HDR_SECOND);
				if (pos_q < SUM_END)
					sum_q <= sum_q + {8'd0, rx_byte};
			end
			if (!pos_q[0])
				hi_q <= rx_byte;
		end
	end

	// word store: every entry is rewritten before the frame is judged
	always_ff @(posedge clk) begin
		if (accept && wr_word)
			store_q[widx] <= {hi_q, rx_byte};
	end

endmodule

// File: hdl/psfr_queue.sv
// Two-entry queue of judged frame records between front and back.
// Uses psfr_pkg.
module psfr_queue import psfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_push_t push,
	output logic        full,
	output logic        head_valid,
	output frame_rec_t  head,
	input  logic        pop
);

	frame_rec_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push.push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push.push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push.push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push)
			ent_q[wr_ptr_q] <= push.rec;
	end

endmodule

// File: hdl/psfr_back.sv
// Back part: walks the head frame record and emits its results, one per cycle
// while res_stall is low; res_stall holds the output register. Uses psfr_pkg.
module psfr_back import psfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  frame_rec_t       head,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [1:0]       frame_status,
	output logic [IDX_W-1:0] word_index,
	output logic [15:0]      word_value,
	output logic             last_of_frame
);

	logic [IDX_W-1:0] idx_q;
	logic             valid_q;
	logic             load;
	logic             err;

	assign res_valid = valid_q;
	assign err       = (head.status != STATUS_OK);
	assign load      = head_valid && (!valid_q || !res_stall);
	assign pop       = load && (err || (idx_q == IDX_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!res_stall)
				valid_q <= 1'b0;
			if (load && !err) begin
				if (idx_q == IDX_LAST)
					idx_q <= '0;
				else
					idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_status <= head.status;
			if (err) begin
				word_index    <= '0;
				word_value    <= '0;
				last_of_frame <= 1'b1;
			end else begin
				word_index    <= idx_q;
				word_value    <= head.words[idx_q];
				last_of_frame <= (idx_q == IDX_LAST);
			end
		end
	end

endmodule
